// ===== hdl/tcld_pkg.sv =====
// Shared widths, register indexes and defaults for the level debouncer.
package tcld_pkg;

	localparam int unsigned CONTACTS_DEF = 3;

	localparam int unsigned PIN_W    = 3;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned LEVEL_W  = 2;
	localparam int unsigned DEB_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);
	localparam logic [PIN_W-1:0] PRESENT_RESET  = PIN_W'(7);
	localparam logic [PIN_W-1:0] NC_RESET       = PIN_W'(0);

	// Highest level that the result field can report.
	localparam int unsigned LEVEL_MAX = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TIME = 2'd0,
		REG_PRESENT_MASK  = 2'd1,
		REG_NC_MASK       = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_INIT   = 1'b0,
		KIND_UPDATE = 1'b1
	} item_kind_t;

endpackage

// ===== hdl/tcld_if.sv =====
// Handshake channels of the level debouncer: sample, result and configuration.
interface tcld_sample_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [tcld_pkg::PIN_W-1:0]   pin_levels;
	logic [tcld_pkg::TIME_W-1:0]  now_ms;
	logic [tcld_pkg::LEVEL_W-1:0] target_level;

	modport source (output valid, kind, pin_levels, now_ms, target_level, input ready);
	modport sink (input valid, kind, pin_levels, now_ms, target_level, output ready);
endinterface

interface tcld_result_if;
	logic                         valid;
	logic                         ready;
	logic [tcld_pkg::LEVEL_W-1:0] current_level;
	logic                         level_reached;
	logic                         tank_empty;

	modport source (output valid, current_level, level_reached, tank_empty, input ready);
	modport sink (input valid, current_level, level_reached, tank_empty, output ready);
endinterface

interface tcld_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tcld_pkg::CFG_IDX_W-1:0] index;
	logic [tcld_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/three_contact_level_debouncer_unit.sv =====
// A sample word passes through the input register and then the result register; a
// result side that is not ready stalls it between the two. Throughput: one sample word per cycle while the result
// side is ready; the per-contact subtract and compare lie between the input register and the result register.
// Reset (arst_n low, asynchronous): configuration, state and valid registers take their default values, the
// block is uninitialized and reports an empty tank until an init sample arrives.
module three_contact_level_debouncer_unit #(
	parameter int unsigned CONTACTS = tcld_pkg::CONTACTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tcld_sample_if.sink       sample,
	tcld_result_if.source     result,
	tcld_cfg_if.sink          cfg
);
	import tcld_pkg::*;

	localparam int unsigned EXT_W = CONTACTS + PIN_W;
	localparam int unsigned LVL_W = $clog2(CONTACTS + 1) + 1;

	// Configuration registers.
	logic [DEB_W-1:0]    debounce_q;
	logic [CONTACTS-1:0] present_q;
	logic [CONTACTS-1:0] nc_q;

	// Debounce state.
	logic                initialized_q;
	logic [CONTACTS-1:0] stable_q;
	logic [CONTACTS-1:0] raw_seen_q;
	logic [TIME_W-1:0]   stamp_q [CONTACTS];

	// Input register.
	logic                valid_s1;
	logic                kind_s1;
	logic [PIN_W-1:0]    pins_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [LEVEL_W-1:0]  target_s1;

	// Result register.
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                reached_q;
	logic                empty_q;

	logic                advance;
	logic [EXT_W-1:0]    pins_ext;
	logic [CONTACTS-1:0] raw;
	logic                init_next;
	logic [CONTACTS-1:0] stable_next;
	logic [CONTACTS-1:0] raw_seen_next;
	logic [CONTACTS-1:0] stamp_load;
	logic [TIME_W-1:0]   elapsed [CONTACTS];
	logic [LVL_W-1:0]    level_full;
	logic [LEVEL_W-1:0]  level_next;
	logic                reached_next;
	logic                empty_next;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	// Pins beyond the contact count are dropped; contacts beyond the pins read low.
	assign pins_ext = EXT_W'(pins_s1);
	assign raw      = ~(pins_ext[CONTACTS-1:0] ^ nc_q) & present_q;

	always_comb begin
		init_next     = initialized_q;
		stable_next   = stable_q;
		raw_seen_next = raw_seen_q;
		stamp_load    = '0;
		for (int i = 0; i < CONTACTS; i++) begin
			elapsed[i] = now_s1 - stamp_q[i];
		end
		if (kind_s1 == KIND_INIT) begin
			init_next     = 1'b1;
			stable_next   = raw;
			raw_seen_next = raw;
			stamp_load    = '1;
		end else if (initialized_q) begin
			for (int i = 0; i < CONTACTS; i++) begin
				if (!present_q[i]) begin
					stable_next[i] = 1'b0;
				end else if (raw[i] != raw_seen_q[i]) begin
					raw_seen_next[i] = raw[i];
					stamp_load[i]    = 1'b1;
				end else if (elapsed[i] >= TIME_W'(debounce_q)) begin
					stable_next[i] = raw[i];
				end
			end
		end
	end

	always_comb begin
		level_full = '0;
		for (int i = 0; i < CONTACTS; i++) begin
			if (stable_next[i]) begin
				level_full = LVL_W'(i + 1);
			end
		end
		if (level_full > LVL_W'(LEVEL_MAX)) begin
			level_next = LEVEL_W'(LEVEL_MAX);
		end else begin
			level_next = level_full[LEVEL_W-1:0];
		end
		if (!init_next) begin
			level_next   = '0;
			reached_next = 1'b0;
			empty_next   = 1'b1;
		end else begin
			reached_next = (level_next >= target_s1);
			empty_next   = (stable_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			present_q  <= CONTACTS'(EXT_W'(PRESENT_RESET));
			nc_q       <= CONTACTS'(EXT_W'(NC_RESET));
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DEBOUNCE_TIME: debounce_q <= cfg.data[DEB_W-1:0];
				REG_PRESENT_MASK:  present_q  <= CONTACTS'(EXT_W'(cfg.data[PIN_W-1:0]));
				REG_NC_MASK:       nc_q       <= CONTACTS'(EXT_W'(cfg.data[PIN_W-1:0]));
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initialized_q <= 1'b0;
			stable_q      <= '0;
			raw_seen_q    <= '0;
			for (int i = 0; i < CONTACTS; i++) begin
				stamp_q[i] <= '0;
			end
		end else if (advance) begin
			initialized_q <= init_next;
			stable_q      <= stable_next;
			raw_seen_q    <= raw_seen_next;
			for (int i = 0; i < CONTACTS; i++) begin
				if (stamp_load[i]) begin
					stamp_q[i] <= now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			kind_s1   <= sample.kind;
			pins_s1   <= sample.pin_levels;
			now_s1    <= sample.now_ms;
			target_s1 <= sample.target_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			level_q   <= level_next;
			reached_q <= reached_next;
			empty_q   <= empty_next;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.current_level = level_q;
	assign result.level_reached = reached_q;
	assign result.tank_empty    = empty_q;

	// A stable contact can only exist once an init sample has been taken.
	a_stable_needs_init: assert property (@(posedge clk) disable iff (!arst_n)
		(stable_q != '0) |-> initialized_q)
		else $error("stable contact flagged before initialization");

	// The input side only stalls while the input register holds a word.
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> valid_s1)
		else $error("sample channel stalled with an empty input register");

	// A non-empty tank always reports some level.
	a_level_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !empty_q) |-> (level_q != '0))
		else $error("non-empty tank reported at level zero");

	// Level zero means an empty tank.
	a_empty_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (level_q == '0)) |-> empty_q)
		else $error("level zero reported without empty flag");

endmodule

// ===== tb/tb_three_contact_level_debouncer_unit.sv =====
// Self-checking testbench for the three-contact level debouncer unit.
module tb_three_contact_level_debouncer_unit;
	import tcld_pkg::*;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               reached;
		logic               empty;
	} level_word_t;

	typedef struct {
		bit                 cfg_first;
		logic [DEB_W-1:0]   deb;
		logic [PIN_W-1:0]   pres;
		logic [PIN_W-1:0]   nc;
		item_kind_t         kind;
		logic [PIN_W-1:0]   pins;
		logic [TIME_W-1:0]  now;
		logic [LEVEL_W-1:0] target;
		bit                 pinned;
		logic [LEVEL_W-1:0] lvl;
		bit                 reached;
		bit                 empty;
	} step_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 95;
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;

	tcld_sample_if smp();
	tcld_result_if res();
	tcld_cfg_if    cfg_ch();

	three_contact_level_debouncer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	// Shadow of the block: settings and debounce state.
	logic [DEB_W-1:0]  deb_ms      = DEBOUNCE_RESET;
	logic [PIN_W-1:0]  fitted_mask = PRESENT_RESET;
	logic [PIN_W-1:0]  nc_mask     = NC_RESET;
	logic              primed      = 1'b0;
	logic [PIN_W-1:0]  stable_set  = '0;
	logic [PIN_W-1:0]  seen_raw    = '0;
	logic [TIME_W-1:0] stamp_ms [CONTACTS_DEF] = '{default: '0};

	level_word_t level_words_due [$];
	int          error_count = 0;
	bit          idle_on = 1'b1;

	// Before init the block reads as empty; the first init rows use the reset settings.
	step_row_t directed_rows [DIRECTED_ROWS] = '{
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b000, 32'd100, 2'd0, 1, 2'd0, 0, 1},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b111, 32'hFFFF_FFFF, 2'd3, 1, 2'd0, 0, 1},
		'{0, 16'd0, 3'd0, 3'd0, KIND_INIT, 3'b111, 32'd1000, 2'd0, 1, 2'd0, 1, 1},
		'{0, 16'd0, 3'd0, 3'd0, KIND_INIT, 3'b000, 32'hFFFF_FFF0, 2'd3, 1, 2'd3, 1, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b001, 32'hFFFF_FFFF, 2'd3, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b001, 32'h0000_0010, 2'd3, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b001, 32'h0000_0022, 2'd3, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b110, 32'h0000_0030, 2'd2, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b110, 32'h0000_0061, 2'd2, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b110, 32'h0000_0062, 2'd1, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b110, 32'hFFFF_FFFF, 2'd0, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_INIT, 3'b101, 32'd0, 2'd2, 1, 2'd2, 1, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_INIT, 3'b011, 32'h8000_0000, 2'd3, 1, 2'd3, 1, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_INIT, 3'b110, 32'h7FFF_FFFF, 2'd2, 1, 2'd1, 0, 0},
		'{1, 16'd0, 3'b101, 3'b010, KIND_INIT, 3'b000, 32'd5, 2'd1, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b010, 32'd5, 2'd2, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b010, 32'd5, 2'd3, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b111, 32'd6, 2'd0, 0, 2'd0, 0, 0},
		'{1, 16'hFFFF, 3'b000, 3'b111, KIND_INIT, 3'b111, 32'd0, 2'd0, 1, 2'd0, 1, 1},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b000, 32'hFFFF_FFFF, 2'd1, 1, 2'd0, 0, 1},
		'{1, 16'hFFFF, 3'b111, 3'b111, KIND_INIT, 3'b111, 32'd0, 2'd3, 1, 2'd3, 1, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b011, 32'd65534, 2'd3, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b011, 32'd65535, 2'd3, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b011, 32'd131069, 2'd3, 0, 2'd0, 0, 0},
		'{0, 16'd0, 3'd0, 3'd0, KIND_UPDATE, 3'b000, 32'hFFFF_FFFF, 2'd2, 0, 2'd0, 0, 0}
	};

	function automatic level_word_t predict_level(item_kind_t kind, logic [PIN_W-1:0] pins,
			logic [TIME_W-1:0] now, logic [LEVEL_W-1:0] target);
		logic [PIN_W-1:0]  raw;
		logic [TIME_W-1:0] elapsed;
		level_word_t       w;
		raw = ~(pins ^ nc_mask) & fitted_mask;
		if (kind == KIND_INIT) begin
			stable_set = raw;
			seen_raw = raw;
			for (int i = 0; i < CONTACTS_DEF; i++)
				stamp_ms[i] = now;
			primed = 1'b1;
		end else if (primed) begin
			for (int i = 0; i < CONTACTS_DEF; i++) begin
				elapsed = now - stamp_ms[i];
				if (!fitted_mask[i]) begin
					stable_set[i] = 1'b0;
				end else if (raw[i] != seen_raw[i]) begin
					seen_raw[i] = raw[i];
					stamp_ms[i] = now;
				end else if (elapsed >= TIME_W'(deb_ms)) begin
					stable_set[i] = raw[i];
				end
			end
		end
		w = '{level: '0, reached: 1'b0, empty: 1'b1};
		if (primed) begin
			for (int i = 0; i < CONTACTS_DEF; i++)
				if (stable_set[i])
					w.level = LEVEL_W'(i + 1);
			w.reached = (w.level >= target);
			w.empty = (stable_set == '0);
		end
		return w;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < 200)
			$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Sender side: an optional gap, then one word held until accepted.
	task automatic send_sample(item_kind_t kind, logic [PIN_W-1:0] pins,
			logic [TIME_W-1:0] now, logic [LEVEL_W-1:0] target, bit pinned,
			level_word_t fixed);
		level_word_t due;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		smp.kind <= kind;
		smp.pin_levels <= pins;
		smp.now_ms <= now;
		smp.target_level <= target;
		smp.valid <= 1'b1;
		do @(posedge clk); while (smp.ready !== 1'b1);
		due = predict_level(kind, pins, now, target);
		if (pinned)
			due = fixed;
		@(negedge clk);
		level_words_due.push_back(due);
	endtask

	task automatic hold_until_idle();
		smp.valid <= 1'b0;
		while (level_words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			REG_DEBOUNCE_TIME: deb_ms = value;
			REG_PRESENT_MASK:  fitted_mask = value[PIN_W-1:0];
			REG_NC_MASK:       nc_mask = value[PIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_settings(logic [DEB_W-1:0] deb, logic [CFG_DAT_W-1:0] pres,
			logic [CFG_DAT_W-1:0] nc);
		hold_until_idle();
		write_reg(REG_DEBOUNCE_TIME, deb);
		write_reg(REG_PRESENT_MASK, pres);
		write_reg(REG_NC_MASK, nc);
		cfg_ch.valid <= 1'b0;
	endtask

	// Receiver side: ready drops for bursts while idling is on.
	initial begin : result_ready_drive
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				res.ready <= 1'b1;
				repeat ($urandom_range(0, 29)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		level_word_t due;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (level_words_due.size() == 0) begin
				report_mismatch("unexpected result word, level", res.current_level, 0);
			end else begin
				due = level_words_due.pop_front();
				if (res.current_level !== due.level)
					report_mismatch("current_level", res.current_level, due.level);
				if (res.level_reached !== due.reached)
					report_mismatch("level_reached", res.level_reached, due.reached);
				if (res.tank_empty !== due.empty)
					report_mismatch("tank_empty", res.tank_empty, due.empty);
			end
		end
	end

	initial begin : stimulus
		level_word_t       fixed;
		level_word_t       none;
		logic [TIME_W-1:0] t;
		logic [PIN_W-1:0]  pins;
		logic [DEB_W-1:0]  deb;
		logic [PIN_W-1:0]  pres;
		logic [PIN_W-1:0]  nc;
		int                left;
		int                run_len;
		none = '0;
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.kind = KIND_INIT;
		smp.pin_levels = '0;
		smp.now_ms = '0;
		smp.target_level = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DEBOUNCE_TIME;
		cfg_ch.data = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].cfg_first)
				load_settings(directed_rows[r].deb, CFG_DAT_W'(directed_rows[r].pres),
					CFG_DAT_W'(directed_rows[r].nc));
			fixed = '{level: directed_rows[r].lvl, reached: directed_rows[r].reached,
				empty: directed_rows[r].empty};
			send_sample(directed_rows[r].kind, directed_rows[r].pins, directed_rows[r].now,
				directed_rows[r].target, directed_rows[r].pinned, fixed);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin deb = '0; pres = 3'b111; nc = 3'b111; end
				1: begin deb = 16'hFFFF; pres = PIN_W'($urandom); nc = PIN_W'($urandom); end
				2: begin deb = 16'd1; pres = 3'b000; nc = 3'b000; end
				default: begin
					deb = ($urandom_range(0, 6) == 0) ? DEB_W'($urandom)
						: DEB_W'($urandom_range(0, 300));
					pres = PIN_W'($urandom);
					nc = PIN_W'($urandom);
				end
			endcase
			load_settings(deb, {13'($urandom), pres}, {13'($urandom), nc});
			// Idling stays off for some phases and for the whole last one.
			idle_on = (ph != PHASES - 1) && ($urandom_range(0, 4) != 0);
			left = PHASE_ITEMS;
			while (left > 0) begin
				// A run is an init word followed by words, mostly updates, with a moving clock.
				run_len = $urandom_range(4, 30);
				if ($urandom_range(0, 3) == 0)
					t = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 2 * deb + 10));
				else
					t = $urandom;
				pins = PIN_W'($urandom);
				send_sample(KIND_INIT, pins, t, LEVEL_W'($urandom), 0, none);
				left--;
				for (int k = 1; k < run_len && left > 0; k++) begin
					case ($urandom_range(0, 15))
						0: send_sample(item_kind_t'(1'($urandom)), PIN_W'($urandom), $urandom,
							LEVEL_W'($urandom), 0, none);
						1: begin
							t = t - TIME_W'($urandom_range(1, 100));
							send_sample(KIND_UPDATE, pins, t, LEVEL_W'($urandom), 0, none);
						end
						default: begin
							if ($urandom_range(0, 3) == 0)
								pins ^= PIN_W'(1 << $urandom_range(0, PIN_W - 1));
							if ($urandom_range(0, 5) == 0)
								t = t + TIME_W'(deb) + TIME_W'($urandom_range(0, 2)) - 1;
							else
								t = t + TIME_W'($urandom_range(0, deb / 4 + 2));
							send_sample(KIND_UPDATE, pins, t, LEVEL_W'($urandom), 0, none);
						end
					endcase
					left--;
				end
			end
		end

		hold_until_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : run_limit
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== three_contact_level_debouncer_unit.f =====
hdl/tcld_pkg.sv
hdl/tcld_if.sv
hdl/three_contact_level_debouncer_unit.sv
tb/tb_three_contact_level_debouncer_unit.sv
